>>> sv/cnms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cnms_pkg;

  localparam logic [15:0] IOU_THR_RESET = 16'd29491;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic [15:0] bottom;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] left;
  } box_t;

  typedef struct packed {
    logic [15:0] score;
    logic [7:0]  class_label;
  } lbl_t;

  typedef struct packed {
    logic valid;
    logic cand;
  } iou_ctl_t;

endpackage
`default_nettype wire

>>> sv/cnms_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cnms_det_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] right;
  logic [15:0] bottom;
  logic [7:0]  class_label;
  logic [15:0] score;

  modport source (output valid, action, left, top, right, bottom, class_label, score,
                  input ready);
  modport sink (input valid, action, left, top, right, bottom, class_label, score,
                output ready);
endinterface

interface cnms_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_res;
  logic [15:0] top_res;
  logic [15:0] right_res;
  logic [15:0] bottom_res;
  logic [7:0]  class_label_res;
  logic [15:0] score_res;
  logic [5:0]  arrival_index;
  logic        last;
  logic        empty_res;
  logic        overflow;

  modport source (output valid, left_res, top_res, right_res, bottom_res, class_label_res,
                  score_res, arrival_index, last, empty_res, overflow,
                  input ready);
  modport sink (input valid, left_res, top_res, right_res, bottom_res, class_label_res,
                score_res, arrival_index, last, empty_res, overflow,
                output ready);
endinterface
`default_nettype wire

>>> sv/class_aware_nms.sv
// Greedy per-class non-maximum suppression.
// Channel det carries requests: action 0 loads one detection into the next
// free slot (one per cycle, no result); action 1 runs suppression over the
// loaded batch. Channel res returns the kept detections in descending score
// order, ties to the lower arrival index, with last set on the final one.
// A run with nothing loaded returns one marker with empty_res and last set.
// Loads beyond MAX_DETECTIONS are dropped and reported through overflow.
// A run takes per kept box one scan of the loaded batch, a fetch of the
// winner and one suppression pass, all set by the single read port of the
// detection memory and the pipelined overlap test, plus the output
// handshake. The block takes no request while a run is in progress; a
// stalled receiver simply holds the run at its result. Reset (rst,
// synchronous) empties the batch and sets the threshold to its default;
// stored detections are not cleared. The threshold is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// since the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module class_aware_nms
  import cnms_pkg::*;
#(
  parameter int MAX_DETECTIONS = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic [15:0] cfg_wdata,
  cnms_det_if.sink    det,
  cnms_res_if.source  res
);

  localparam int IW = $clog2(MAX_DETECTIONS);
  localparam int CW = $clog2(MAX_DETECTIONS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_DETECTIONS);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FETCH, S_FWAIT, S_SUPP, S_EMIT} state_t;

  state_t                  state;
  logic [15:0]             thr;
  logic [CW-1:0]           cnt;
  logic                    ovf;
  logic [MAX_DETECTIONS-1:0] done;
  logic [CW-1:0]           iss, rcnt;
  logic                    pv;
  logic [IW-1:0]           pidx;
  logic                    bf;
  logic [IW-1:0]           bidx;
  logic [15:0]             bscore;
  logic [7:0]              bclass;
  box_t                    bbox;

  logic          st_we;
  logic [IW-1:0] raddr;
  box_t          rbox, wbox;
  lbl_t          rlbl, wlbl;
  iou_ctl_t      ictl;
  logic          rsp_valid, rsp_hit;
  logic [IW-1:0] rsp_idx;
  logic          remaining;
  logic          acc;

  assign acc   = det.valid && det.ready;
  assign st_we = (state == S_IDLE) && acc && (det.action == ACT_LOAD) && (cnt < CAP);
  assign wbox  = '{bottom: det.bottom, right: det.right, top: det.top, left: det.left};
  assign wlbl  = '{score: det.score, class_label: det.class_label};
  assign raddr = (state == S_FETCH) ? bidx : iss[IW-1:0];
  assign det.ready = (state == S_IDLE);

  assign ictl.valid = (state == S_SUPP) && pv;
  assign ictl.cand  = (rlbl.class_label == bclass);

  always_comb begin
    remaining = 1'b0;
    for (int i = 0; i < MAX_DETECTIONS; i++) begin
      if ((CW'(i) < cnt) && !done[i]) remaining = 1'b1;
    end
  end

  cnms_store #(.DEPTH(MAX_DETECTIONS), .IW(IW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt[IW-1:0]),
    .wbox  (wbox),
    .wlbl  (wlbl),
    .raddr (raddr),
    .rbox  (rbox),
    .rlbl  (rlbl)
  );

  cnms_iou #(.IW(IW)) u_iou (
    .clk       (clk),
    .rst       (rst),
    .req       (ictl),
    .req_idx   (pidx),
    .box_a     (bbox),
    .box_b     (rbox),
    .thr       (thr),
    .rsp_valid (rsp_valid),
    .rsp_hit   (rsp_hit),
    .rsp_idx   (rsp_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      thr       <= IOU_THR_RESET;
      cnt       <= '0;
      ovf       <= 1'b0;
      done      <= '0;
      pv        <= 1'b0;
      bf        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (det.action == ACT_LOAD) begin
              if (cnt < CAP) cnt <= cnt + 1'b1;
              else ovf <= 1'b1;
            end else if (cnt == '0) begin
              res.left_res        <= '0;
              res.top_res         <= '0;
              res.right_res       <= '0;
              res.bottom_res      <= '0;
              res.class_label_res <= '0;
              res.score_res       <= '0;
              res.arrival_index   <= '0;
              res.last            <= 1'b1;
              res.empty_res       <= 1'b1;
              res.overflow        <= ovf;
              res.valid           <= 1'b1;
              state               <= S_EMIT;
            end else begin
              iss   <= '0;
              pv    <= 1'b0;
              bf    <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Strict compare keeps the lower index on equal scores.
          if (pv && !done[pidx] && (!bf || rlbl.score > bscore)) begin
            bf     <= 1'b1;
            bidx   <= pidx;
            bscore <= rlbl.score;
            bclass <= rlbl.class_label;
          end
          if (iss < cnt) begin
            iss  <= iss + 1'b1;
            pv   <= 1'b1;
            pidx <= iss[IW-1:0];
          end else begin
            pv <= 1'b0;
            if (!pv) state <= S_FETCH;
          end
        end
        S_FETCH: begin
          done[bidx] <= 1'b1;
          state      <= S_FWAIT;
        end
        S_FWAIT: begin
          bbox  <= rbox;
          iss   <= '0;
          rcnt  <= '0;
          pv    <= 1'b0;
          state <= S_SUPP;
        end
        S_SUPP: begin
          if (iss < cnt) begin
            iss  <= iss + 1'b1;
            pv   <= 1'b1;
            pidx <= iss[IW-1:0];
          end else begin
            pv <= 1'b0;
          end
          if (rsp_valid) begin
            rcnt <= rcnt + 1'b1;
            if (rsp_hit) done[rsp_idx] <= 1'b1;
          end
          if (rcnt == cnt) begin
            res.left_res        <= bbox.left;
            res.top_res         <= bbox.top;
            res.right_res       <= bbox.right;
            res.bottom_res      <= bbox.bottom;
            res.class_label_res <= bclass;
            res.score_res       <= bscore;
            res.arrival_index   <= 6'(bidx);
            res.last            <= !remaining;
            res.empty_res       <= 1'b0;
            res.overflow        <= ovf;
            res.valid           <= 1'b1;
            state               <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            if (res.last) begin
              cnt   <= '0;
              done  <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              iss   <= '0;
              pv    <= 1'b0;
              bf    <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/cnms_store.sv
`timescale 1ns / 1ps
`default_nettype none
module cnms_store
  import cnms_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire box_t          wbox,
  input  wire lbl_t          wlbl,
  input  wire logic [IW-1:0] raddr,
  output box_t               rbox,
  output lbl_t               rlbl
);

  box_t box_mem [DEPTH];
  lbl_t lbl_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      box_mem[waddr] <= wbox;
      lbl_mem[waddr] <= wlbl;
    end
    rbox <= box_mem[raddr];
    rlbl <= lbl_mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/cnms_iou.sv
`timescale 1ns / 1ps
`default_nettype none
module cnms_iou
  import cnms_pkg::*;
#(
  parameter int IW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire iou_ctl_t      req,
  input  wire logic [IW-1:0] req_idx,
  input  wire box_t          box_a,
  input  wire box_t          box_b,
  input  wire logic [15:0]   thr,
  output logic               rsp_valid,
  output logic               rsp_hit,
  output logic [IW-1:0]      rsp_idx
);

  // Stage 1: intersection edges and extents.
  logic          s1_v, s1_ov;
  logic [IW-1:0] s1_idx;
  logic [15:0]   s1_dw, s1_dh, s1_aw, s1_ah, s1_bw, s1_bh;
  // Stage 2: areas.
  logic          s2_v, s2_ov;
  logic [IW-1:0] s2_idx;
  logic [31:0]   s2_inter, s2_aa, s2_ab;
  // Stage 3: union.
  logic          s3_v, s3_ov;
  logic [IW-1:0] s3_idx;
  logic [31:0]   s3_inter;
  logic [32:0]   s3_uni;
  // Stage 4: threshold times union.
  logic          s4_v, s4_ov;
  logic [IW-1:0] s4_idx;
  logic [31:0]   s4_inter;
  logic [48:0]   s4_prod;

  logic [15:0] il, it, ir, ib;

  always_comb begin
    il = (box_a.left > box_b.left) ? box_a.left : box_b.left;
    it = (box_a.top > box_b.top) ? box_a.top : box_b.top;
    ir = (box_a.right < box_b.right) ? box_a.right : box_b.right;
    ib = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_v      <= req.valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      rsp_valid <= s4_v;
    end
    s1_idx <= req_idx;
    s1_ov  <= req.cand && (ir > il) && (ib > it);
    s1_dw  <= ir - il;
    s1_dh  <= ib - it;
    s1_aw  <= box_a.right - box_a.left;
    s1_ah  <= box_a.bottom - box_a.top;
    s1_bw  <= box_b.right - box_b.left;
    s1_bh  <= box_b.bottom - box_b.top;

    s2_idx   <= s1_idx;
    s2_ov    <= s1_ov;
    s2_inter <= s1_dw * s1_dh;
    s2_aa    <= s1_aw * s1_ah;
    s2_ab    <= s1_bw * s1_bh;

    s3_idx   <= s2_idx;
    s3_ov    <= s2_ov;
    s3_inter <= s2_inter;
    s3_uni   <= {1'b0, s2_aa} + {1'b0, s2_ab} - {1'b0, s2_inter};

    s4_idx   <= s3_idx;
    s4_ov    <= s3_ov;
    s4_inter <= s3_inter;
    s4_prod  <= 49'(thr) * 49'(s3_uni);

    rsp_idx <= s4_idx;
    rsp_hit <= s4_ov && ({1'b0, s4_inter, 16'h0000} > s4_prod);
  end

endmodule
`default_nettype wire

>>> sv/cnms_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module cnms_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        det_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic        res_last,
  input wire logic        res_empty,
  input wire logic [15:0] res_score
);

  // A result that waits for the receiver must stay offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Requests are refused whenever a result is offered.
  a_busy: assert property (@(posedge clk) disable iff (rst) !(det_ready && res_valid))
    else $error("request taken while a result is offered");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_empty |-> res_last && (res_score == 16'h0000))
    else $error("empty marker malformed");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

endmodule

bind class_aware_nms cnms_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .det_ready (det.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_last  (res.last),
  .res_empty (res.empty_res),
  .res_score (res.score_res)
);
`default_nettype wire

>>> bench/class_aware_nms_test.sv
`timescale 1ns / 1ps
module class_aware_nms_test;
  import cnms_pkg::*;

  typedef struct {
    logic [15:0] left, top, right, bottom;
    logic [7:0]  class_label;
    logic [15:0] score;
    logic [5:0]  arrival_index;
    logic        last, empty_res, overflow;
  } kept_t;

  class nms_scoreboard;
    box_t        boxes[64];
    logic [7:0]  labels[64];
    logic [15:0] scores[64];
    int          held;
    bit          dropped;
    logic [15:0] threshold;
    kept_t       pending[$];
    int          mismatches;
    int          results_seen;
    int          runs;

    function new();
      held = 0;
      dropped = 0;
      threshold = IOU_THR_RESET;
      mismatches = 0;
      results_seen = 0;
      runs = 0;
    endfunction

    function bit overlaps_too_much(box_t a, box_t b);
      logic [15:0] il, it, ir, ib;
      logic [63:0] inter, area_a, area_b, uni;
      il = (a.left > b.left) ? a.left : b.left;
      it = (a.top > b.top) ? a.top : b.top;
      ir = (a.right < b.right) ? a.right : b.right;
      ib = (a.bottom < b.bottom) ? a.bottom : b.bottom;
      if (ir <= il || ib <= it) return 0;
      inter = 64'(ir - il) * 64'(ib - it);
      area_a = 64'(a.right - a.left) * 64'(a.bottom - a.top);
      area_b = 64'(b.right - b.left) * 64'(b.bottom - b.top);
      uni = area_a + area_b - inter;
      return (inter << 16) > 64'(threshold) * uni;
    endfunction

    function void note_request(logic act, box_t b, logic [7:0] cls, logic [15:0] sc);
      bit    handled[64];
      int    best, k;
      kept_t r;
      if (act == ACT_LOAD) begin
        if (held < 64) begin
          boxes[held] = b;
          labels[held] = cls;
          scores[held] = sc;
          held++;
        end else begin
          dropped = 1;
        end
        return;
      end
      runs++;
      if (held == 0) begin
        r = '{default: 0};
        r.last = 1;
        r.empty_res = 1;
        r.overflow = dropped;
        pending = {pending, r};
      end else begin
        for (k = 0; k < 64; k++) handled[k] = 0;
        forever begin
          best = -1;
          for (k = 0; k < held; k++)
            if (!handled[k] && (best < 0 || scores[k] > scores[best])) best = k;
          if (best < 0) break;
          handled[best] = 1;
          for (k = 0; k < held; k++)
            if (!handled[k] && labels[k] == labels[best] &&
                overlaps_too_much(boxes[best], boxes[k]))
              handled[k] = 1;
          r.left = boxes[best].left;
          r.top = boxes[best].top;
          r.right = boxes[best].right;
          r.bottom = boxes[best].bottom;
          r.class_label = labels[best];
          r.score = scores[best];
          r.arrival_index = 6'(best);
          r.last = 0;
          r.empty_res = 0;
          r.overflow = dropped;
          pending = {pending, r};
        end
        pending[pending.size() - 1].last = 1;
      end
      held = 0;
      dropped = 0;
    endfunction

    function void check_result(kept_t got);
      kept_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
          got.bottom !== want.bottom || got.class_label !== want.class_label ||
          got.score !== want.score || got.arrival_index !== want.arrival_index ||
          got.last !== want.last || got.empty_res !== want.empty_res ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;

  cnms_det_if det ();
  cnms_res_if res ();

  class_aware_nms uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .det(det), .res(res)
  );

  always #10 clk = ~clk;

  nms_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  bit hold_go = 0;
  bit hold_seen = 0;
  int hold_off = 0;
  int quiet_cycles = 0;
  int sent = 0;

  // The receiver honors a long hold-off when one is asked for, then idles at random.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_off <= hold_len;
      res.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    kept_t got;
    if (!rst && res.valid && res.ready) begin
      got.left = res.left_res;
      got.top = res.top_res;
      got.right = res.right_res;
      got.bottom = res.bottom_res;
      got.class_label = res.class_label_res;
      got.score = res.score_res;
      got.arrival_index = res.arrival_index;
      got.last = res.last;
      got.empty_res = res.empty_res;
      got.overflow = res.overflow;
      board.check_result(got);
    end
  end

  // The limit on quiet cycles covers the longest gap between results of a
  // full run plus the longest stall several times over.
  always @(posedge clk) begin
    if (rst || (det.valid && det.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 60000) begin
      $display("Timeout with %0d results outstanding", board.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The request stays offered after acceptance until the next request or a pause
  // replaces it, so valid gets one assignment per clock edge.
  task automatic send_request(logic act, box_t b, logic [7:0] cls, logic [15:0] sc);
    while ($urandom_range(99) < send_idle_pct) begin
      det.valid <= 0;
      @(posedge clk);
    end
    det.valid <= 1;
    det.action <= act;
    det.left <= b.left;
    det.top <= b.top;
    det.right <= b.right;
    det.bottom <= b.bottom;
    det.class_label <= cls;
    det.score <= sc;
    do @(posedge clk); while (!det.ready);
    board.note_request(act, b, cls, sc);
    sent++;
  endtask

  task automatic load_box(box_t b, logic [7:0] cls, logic [15:0] sc);
    send_request(ACT_LOAD, b, cls, sc);
  endtask

  task automatic run_batch();
    send_request(ACT_RUN, '0, 8'd0, 16'd0);
  endtask

  task automatic drain();
    det.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] value);
    drain();
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.threshold = value;
  endtask

  function automatic box_t random_box(bit wide);
    box_t b;
    if (wide) begin
      b = {$urandom, $urandom};
    end else begin
      b.left = 16'($urandom_range(400));
      b.top = 16'($urandom_range(400));
      b.right = b.left + 16'($urandom_range(300)) - 16'(($urandom_range(9) == 0) ? 20 : 0);
      b.bottom = b.top + 16'($urandom_range(300));
    end
    return b;
  endfunction

  // A clustered batch: boxes jittered around a few centers so suppression bites.
  task automatic random_batch(int count);
    box_t  b;
    box_t  centers[4];
    int    k, c;
    for (k = 0; k < 4; k++) centers[k] = random_box(0);
    for (k = 0; k < count; k++) begin
      c = $urandom_range(3);
      b = centers[c];
      b.left += 16'($urandom_range(12));
      b.top += 16'($urandom_range(12));
      b.right += 16'($urandom_range(12));
      b.bottom += 16'($urandom_range(12));
      if ($urandom_range(7) == 0) b = random_box($urandom_range(1));
      load_box(b, 8'($urandom_range(2) == 0 ? $urandom : $urandom_range(2)),
               ($urandom_range(9) == 0) ? 16'd1000 : 16'($urandom));
    end
    run_batch();
  endtask

  initial begin
    int phase, k;
    det.valid = 0;
    det.action = ACT_LOAD;
    det.left = 0;
    det.top = 0;
    det.right = 0;
    det.bottom = 0;
    det.class_label = 0;
    det.score = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty run, full extremes, identical boxes, ties and disjoint boxes.
    run_batch();
    load_box('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 8'hFF, 16'hFFFF);
    load_box('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 8'hFF, 16'hFFFF);
    load_box('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 8'h00, 16'h0000);
    load_box('{16'h0010, 16'h0010, 16'h0000, 16'h0000}, 8'hFF, 16'h0000);
    load_box('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 8'h01, 16'h8000);
    run_batch();
    load_box('{16'd200, 16'd200, 16'd100, 16'd100}, 8'd3, 16'd500);
    load_box('{16'd300, 16'd300, 16'd200, 16'd200}, 8'd3, 16'd500);
    load_box('{16'd210, 16'd210, 16'd110, 16'd110}, 8'd3, 16'd400);
    load_box('{16'd210, 16'd210, 16'd110, 16'd110}, 8'd4, 16'd400);
    run_batch();
    set_threshold(16'd0);
    for (k = 0; k < 3; k++) load_box('{16'd50, 16'd50, 16'd0, 16'd0}, 8'd7, 16'(k));
    run_batch();
    set_threshold(16'hFFFF);
    for (k = 0; k < 3; k++) load_box('{16'd50, 16'd50, 16'd0, 16'd0}, 8'd7, 16'(k));
    run_batch();

    // Overflow: fill past capacity with the receiver held off.
    set_threshold(IOU_THR_RESET);
    hold_len = 400;
    hold_go = ~hold_go;
    for (k = 0; k < 66; k++) load_box(random_box(0), 8'($urandom_range(3)), 16'($urandom));
    run_batch();
    run_batch();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 37 : 0;
      set_threshold(16'($urandom_range(65535)));
      for (k = 0; k < 5; k++) random_batch($urandom_range(1, 12));
      if (phase == 2) begin
        hold_len = 300;
        hold_go = ~hold_go;
      end
      random_batch($urandom_range(1, 10));
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    repeat (50) @(posedge clk);

    $display("Sent %0d requests over %0d runs, checked %0d kept boxes.",
             sent, board.runs, board.results_seen);
    $display("Thresholds covered zero, full scale, default and random values.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/cnms_pkg.sv
sv/cnms_if.sv
sv/cnms_store.sv
sv/cnms_iou.sv
sv/class_aware_nms.sv
sv/cnms_chk.sv
bench/class_aware_nms_test.sv
